>>> rtl/core/ctcgd_pkg.sv
package ctcgd_pkg;

	// fixed field widths
	localparam int LOGIT_W      = 16;
	localparam int TOK_W        = 12;
	localparam int FRAME_IDX_W  = 16;
	localparam int MS_W         = 24;
	localparam int FRAME_MS_W   = 8;
	localparam int VOCAB_SZ_W   = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK_TOKEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS    = 2'd2;

	// register reset values
	localparam logic [VOCAB_SZ_W-1:0] VOCAB_SIZE_RST  = 13'd512;
	localparam logic [TOK_W-1:0]      BLANK_TOKEN_RST = 12'd0;
	localparam logic [FRAME_MS_W-1:0] FRAME_MS_RST    = 8'd40;

	// reserved ids: tracked as previous token but never emitted
	localparam logic [TOK_W-1:0] TOK_RSVD_A = 12'd1;
	localparam logic [TOK_W-1:0] TOK_RSVD_B = 12'd2;
	localparam logic [TOK_W-1:0] TOK_RSVD_C = 12'd3;

	localparam logic [MS_W-1:0] MS_MAX = 24'hFFFFFF;

	// frame decision handed from argmax to collapse
	typedef struct packed {
		logic             close;
		logic             eou;
		logic [TOK_W-1:0] tok;
	} frame_close_t;

endpackage

>>> rtl/core/ctcgd_logit_if.sv
interface ctcgd_logit_if;
	import ctcgd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [LOGIT_W-1:0] logit_value;
	logic                      end_of_utterance;

	modport source (output valid, logit_value, end_of_utterance, input ready);
	modport sink   (input valid, logit_value, end_of_utterance, output ready);
endinterface

>>> rtl/core/ctcgd_token_if.sv
interface ctcgd_token_if;
	import ctcgd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [TOK_W-1:0]       token_id;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic [MS_W-1:0]        start_ms;
	logic [MS_W-1:0]        end_ms;

	modport source (output valid, token_id, frame_index, start_ms, end_ms, input ready);
	modport sink   (input valid, token_id, frame_index, start_ms, end_ms, output ready);
endinterface

>>> rtl/core/ctcgd_cfg_if.sv
interface ctcgd_cfg_if;
	import ctcgd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ctcgd_frame_argmax.sv
module ctcgd_frame_argmax #(
	parameter int MAX_VOCAB   = 4096,
	parameter int SCORE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic signed [ctcgd_pkg::LOGIT_W-1:0] logit_value,
	input  logic                                 end_of_utterance,
	input  logic [ctcgd_pkg::VOCAB_SZ_W-1:0]     vocab_size,
	output ctcgd_pkg::frame_close_t              fc
);
	import ctcgd_pkg::*;

	localparam int POS_W = $clog2(MAX_VOCAB);
	localparam logic signed [32:0] S_HI = (33'sd1 <<< (SCORE_WIDTH - 1)) - 33'sd1;
	localparam logic signed [32:0] S_LO = -S_HI - 33'sd1;

	logic signed [SCORE_WIDTH-1:0] best_score_q;
	logic [TOK_W-1:0]              best_idx_q;
	logic [POS_W-1:0]              pos_q;

	logic signed [32:0]            score_ext;
	logic signed [SCORE_WIDTH-1:0] score;
	logic [POS_W-1:0]              last_pos;
	logic                          take;
	logic [TOK_W-1:0]              best_idx_nxt;

	// saturate the logit into the score range
	always_comb begin
		score_ext = 33'(logit_value);
		if (score_ext > S_HI) begin
			score = SCORE_WIDTH'(S_HI);
		end else if (score_ext < S_LO) begin
			score = SCORE_WIDTH'(S_LO);
		end else begin
			score = SCORE_WIDTH'(score_ext);
		end
	end

	// frame length: zero means one, clipped to MAX_VOCAB
	always_comb begin
		if (vocab_size == '0) begin
			last_pos = '0;
		end else if (32'(vocab_size) > MAX_VOCAB) begin
			last_pos = POS_W'(MAX_VOCAB - 1);
		end else begin
			last_pos = POS_W'(32'(vocab_size) - 32'd1);
		end
	end

	// strictly greater wins, so the first index keeps ties
	assign take         = (pos_q == '0) || (score > best_score_q);
	assign best_idx_nxt = take ? TOK_W'(32'(pos_q)) : best_idx_q;

	assign fc.close = (pos_q >= last_pos) || end_of_utterance;
	assign fc.eou   = end_of_utterance;
	assign fc.tok   = best_idx_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_idx_q   <= '0;
			pos_q        <= '0;
		end else if (fire) begin
			if (take) begin
				best_score_q <= score;
			end
			best_idx_q <= best_idx_nxt;
			pos_q      <= fc.close ? '0 : pos_q + POS_W'(1);
		end
	end
endmodule

>>> rtl/core/ctcgd_collapse.sv
module ctcgd_collapse #(
	parameter int FRAME_COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic                               adv,
	input  ctcgd_pkg::frame_close_t            fc,
	input  logic [ctcgd_pkg::TOK_W-1:0]        blank_token,
	output logic                               valid_s1,
	output logic [ctcgd_pkg::TOK_W-1:0]        tok_s1,
	output logic [FRAME_COUNT_WIDTH-1:0]       frame_s1
);
	import ctcgd_pkg::*;

	logic [TOK_W-1:0]             prev_tok_q;
	logic                         prev_vld_q;
	logic [FRAME_COUNT_WIDTH-1:0] frame_cnt_q;

	logic is_blank;
	logic is_repeat;
	logic is_rsvd;
	logic emit;

	assign is_blank  = (fc.tok == blank_token);
	assign is_repeat = prev_vld_q && (fc.tok == prev_tok_q);
	assign is_rsvd   = (fc.tok == TOK_RSVD_A) || (fc.tok == TOK_RSVD_B) ||
	                   (fc.tok == TOK_RSVD_C);
	assign emit      = fc.close && !is_blank && !is_repeat && !is_rsvd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tok_q  <= '0;
			prev_vld_q  <= 1'b0;
			frame_cnt_q <= '0;
		end else if (fire && fc.close) begin
			// a repeat leaves the last token as it is
			if (!is_blank && !is_repeat) begin
				prev_tok_q <= fc.tok;
			end
			// utterance end restarts numbering and forgets the last token
			if (fc.eou) begin
				frame_cnt_q <= '0;
				prev_vld_q  <= 1'b0;
			end else begin
				// blank clears history; a repeat only occurs with it already set
				prev_vld_q <= !is_blank;
				if (frame_cnt_q != '1) begin
					frame_cnt_q <= frame_cnt_q + FRAME_COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1   <= fc.tok;
			frame_s1 <= frame_cnt_q;
		end
	end
endmodule

>>> rtl/core/ctcgd_timestamp.sv
module ctcgd_timestamp #(
	parameter int FRAME_COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                valid_s1,
	input  logic [ctcgd_pkg::TOK_W-1:0]         tok_s1,
	input  logic [FRAME_COUNT_WIDTH-1:0]        frame_s1,
	input  logic [ctcgd_pkg::FRAME_MS_W-1:0]    frame_ms,
	ctcgd_token_if.source                       tokens
);
	import ctcgd_pkg::*;

	localparam int PROD_W = FRAME_COUNT_WIDTH + FRAME_MS_W;

	logic [PROD_W-1:0] prod;
	logic [MS_W-1:0]   start_sat;
	logic [MS_W:0]     end_sum;
	logic [MS_W-1:0]   end_sat;

	logic                   valid_s2;
	logic [TOK_W-1:0]       tok_s2;
	logic [FRAME_IDX_W-1:0] frame_s2;
	logic [MS_W-1:0]        start_s2;
	logic [MS_W-1:0]        end_s2;

	always_comb begin
		prod = PROD_W'(frame_s1) * PROD_W'(frame_ms);
		if (64'(prod) > 64'(MS_MAX)) begin
			start_sat = MS_MAX;
		end else begin
			start_sat = MS_W'(prod);
		end
		end_sum = {1'b0, start_sat} + (MS_W + 1)'(frame_ms);
		end_sat = end_sum[MS_W] ? MS_MAX : end_sum[MS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2   <= tok_s1;
			frame_s2 <= FRAME_IDX_W'(32'(frame_s1));
			start_s2 <= start_sat;
			end_s2   <= end_sat;
		end
	end

	assign tokens.valid       = valid_s2;
	assign tokens.token_id    = tok_s2;
	assign tokens.frame_index = frame_s2;
	assign tokens.start_ms    = start_s2;
	assign tokens.end_ms      = end_s2;
endmodule

>>> rtl/core/ctc_greedy_token_decoder_top.sv
// CTC greedy token decoder, one logit beat per cycle.
// Throughput: one logit accepted every cycle while the token side keeps up.
// After the beat that closes its frame, a token passes the collapse register,
// then the timestamp multiply into the output register, before it appears.
// Reset (arst_n low) clears argmax, collapse state and pipeline valids and
// restores vocab_size 512, blank_token 0, frame_ms 40.
module ctc_greedy_token_decoder_top #(
	parameter int MAX_VOCAB         = 4096,
	parameter int SCORE_WIDTH       = 16,
	parameter int FRAME_COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ctcgd_logit_if.sink   logits,
	ctcgd_token_if.source tokens,
	ctcgd_cfg_if.sink     cfg
);
	import ctcgd_pkg::*;

	// configuration registers
	logic [VOCAB_SZ_W-1:0] vocab_size_q;
	logic [TOK_W-1:0]      blank_token_q;
	logic [FRAME_MS_W-1:0] frame_ms_q;

	// pipeline control
	logic fire;
	logic adv1;
	logic adv2;

	frame_close_t                 fc;
	logic                         valid_s1;
	logic [TOK_W-1:0]             tok_s1;
	logic [FRAME_COUNT_WIDTH-1:0] frame_s1;

	// Config channel never stalls; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_size_q  <= VOCAB_SIZE_RST;
			blank_token_q <= BLANK_TOKEN_RST;
			frame_ms_q    <= FRAME_MS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VOCAB_SIZE:  vocab_size_q  <= cfg.data[VOCAB_SZ_W-1:0];
				CFG_BLANK_TOKEN: blank_token_q <= cfg.data[TOK_W-1:0];
				CFG_FRAME_MS:    frame_ms_q    <= cfg.data[FRAME_MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register frees when empty or taken this cycle; the collapse
	// register moves whenever the output register can take it or it is empty.
	// A logit beat is taken whenever the collapse register can move, so frames
	// that yield no token never hold up the stream.
	assign adv2         = !tokens.valid || tokens.ready;
	assign adv1         = adv2 || !valid_s1;
	assign logits.ready = adv1;
	assign fire         = logits.valid && adv1;

	// running argmax over the frame, closes on frame length or utterance end
	ctcgd_frame_argmax #(
		.MAX_VOCAB   (MAX_VOCAB),
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_argmax (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.logit_value      (logits.logit_value),
		.end_of_utterance (logits.end_of_utterance),
		.vocab_size       (vocab_size_q),
		.fc               (fc)
	);

	// blank / repeat / reserved-id collapse and frame numbering
	ctcgd_collapse #(
		.FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
	) u_collapse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.adv         (adv1),
		.fc          (fc),
		.blank_token (blank_token_q),
		.valid_s1    (valid_s1),
		.tok_s1      (tok_s1),
		.frame_s1    (frame_s1)
	);

	// frame_index * frame_ms with 24-bit saturation, drives the token beat
	ctcgd_timestamp #(
		.FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
	) u_timestamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv2),
		.valid_s1 (valid_s1),
		.tok_s1   (tok_s1),
		.frame_s1 (frame_s1),
		.frame_ms (frame_ms_q),
		.tokens   (tokens)
	);
endmodule
